// File: src/lkx_pkg.sv
// Shared types and constants for the LCG keystream XOR cipher.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package lkx_pkg;

  // Generator word and divider sizing
  localparam int unsigned WordW    = 32;
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Configuration port sizing: four 32-bit registers at byte address 4*i
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned AddrW   = RegIdxW + 2;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_SEED       = 2'd0;
  localparam logic [RegIdxW-1:0] REG_MULTIPLIER = 2'd1;
  localparam logic [RegIdxW-1:0] REG_INCREMENT  = 2'd2;
  localparam logic [RegIdxW-1:0] REG_MODULUS    = 2'd3;

  // Reset values
  localparam logic [WordW-1:0] SEED_RST       = 32'd12345;
  localparam logic [WordW-1:0] MULTIPLIER_RST = 32'd1664525;
  localparam logic [WordW-1:0] INCREMENT_RST  = 32'd1013904223;
  localparam logic [WordW-1:0] MODULUS_RST    = 32'hFFFF_FFFF;

  // Transaction payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } lkx_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } lkx_out_t;

  // Register write request from the bus decode
  typedef struct packed {
    logic               we;
    logic [RegIdxW-1:0] idx;
    logic [WordW-1:0]   wdata;
  } lkx_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture input transaction
    logic mul;     // multiplier * state
    logic add;     // + increment, start division
    logic step;    // one restoring remainder step
    logic commit;  // update state, load output register
  } lkx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } lkx_sts_t;

endpackage

// File: src/lkx_ctrl.sv
// Sequencing state machine and output valid for the LCG cipher.
// Depends on lkx_pkg; drives commands to lkx_dpath.
`timescale 1ns / 1ps

module lkx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lkx_pkg::lkx_sts_t sts_i,
  output lkx_pkg::lkx_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       can_commit;

  // Output register is free when empty or being drained this cycle
  assign can_commit = !out_vld_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (can_commit) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_vld_d = cmd_o.commit | (out_vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// File: src/lkx_dpath.sv
// Datapath of the LCG cipher: configuration registers, generator state,
// multiply-add and restoring remainder unit. Depends on lkx_pkg.
`timescale 1ns / 1ps

module lkx_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkx_pkg::lkx_cmd_t         cmd_i,
  output lkx_pkg::lkx_sts_t         sts_o,
  input  lkx_pkg::lkx_in_t          in_data_i,
  output lkx_pkg::lkx_out_t         out_data_o,
  input  lkx_pkg::lkx_cfg_t         cfg_i,
  input  logic [lkx_pkg::RegIdxW-1:0] rd_idx_i,
  output logic [lkx_pkg::WordW-1:0] rd_data_o
);

  localparam int unsigned W = lkx_pkg::WordW;

  logic [W-1:0] seed_q, mult_q, incr_q, mod_q, gen_q;
  lkx_pkg::lkx_in_t  in_q;
  lkx_pkg::lkx_out_t out_q;
  logic [W-1:0] prod_q, dvd_q, rem_q;
  logic [lkx_pkg::CntW-1:0] cnt_q;
  logic [W+1:0] trial;

  // Configuration registers and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= lkx_pkg::SEED_RST;
      mult_q <= lkx_pkg::MULTIPLIER_RST;
      incr_q <= lkx_pkg::INCREMENT_RST;
      mod_q  <= lkx_pkg::MODULUS_RST;
      gen_q  <= lkx_pkg::SEED_RST;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          lkx_pkg::REG_SEED: begin
            seed_q <= cfg_i.wdata;
            gen_q  <= cfg_i.wdata;
          end
          lkx_pkg::REG_MULTIPLIER: mult_q <= cfg_i.wdata;
          lkx_pkg::REG_INCREMENT:  incr_q <= cfg_i.wdata;
          lkx_pkg::REG_MODULUS: begin
            // a zero modulus is refused
            if (cfg_i.wdata != '0) begin
              mod_q <= cfg_i.wdata;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        gen_q <= rem_q;
      end
    end
  end

  // Register readback
  always_comb begin
    case (rd_idx_i)
      lkx_pkg::REG_SEED:       rd_data_o = seed_q;
      lkx_pkg::REG_MULTIPLIER: rd_data_o = mult_q;
      lkx_pkg::REG_INCREMENT:  rd_data_o = incr_q;
      lkx_pkg::REG_MODULUS:    rd_data_o = mod_q;
      default:                 rd_data_o = '0;
    endcase
  end

  // Restoring step: shift next dividend bit into the partial remainder
  assign trial = {1'b0, rem_q, dvd_q[W-1]} - {2'b00, mod_q};

  // Arithmetic pipeline registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      prod_q <= mult_q * gen_q;  // low word only, mod 2^32
    end
    if (cmd_i.add) begin
      dvd_q <= prod_q + incr_q;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.step) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (trial[W+1]) begin
        rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
      end else begin
        rem_q <= trial[W-1:0];
      end
    end
    if (cmd_i.commit) begin
      out_q.out_byte <= in_q.data_byte ^ rem_q[7:0];
      out_q.out_last <= in_q.is_last;
    end
  end

  assign sts_o.div_done = (cnt_q == lkx_pkg::CntW'(lkx_pkg::DivSteps - 1));
  assign out_data_o     = out_q;

endmodule

// File: src/lcg_keystream_xor_cipher.sv
// Top level of the LCG keystream XOR cipher: bus decode plus controller
// and datapath. Depends on lkx_pkg, lkx_ctrl and lkx_dpath.
`timescale 1ns / 1ps

// Each accepted byte is XORed with the low byte of the next LCG state,
// state = ((multiplier * state + increment) mod 2^32) mod modulus. One byte
// is processed at a time: after the input transaction the block runs a
// multiply step, an add step, the restoring remainder unit (one step per
// dividend bit) and a commit step, and the next byte can be taken in the
// cycle after the commit. The output register holds a finished result
// while the next byte is worked on; commit waits only if that register is
// still full. Registers sit at byte addresses 0 seed, 4 multiplier,
// 8 increment, 12 modulus; writing the seed also reloads the generator
// state and a zero modulus write is ignored.
// Registers are to be written only while no byte is in flight.
module lcg_keystream_xor_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lkx_pkg::lkx_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lkx_pkg::lkx_out_t         out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lkx_pkg::AddrW-1:0] paddr,
  input  logic [lkx_pkg::WordW-1:0] pwdata,
  output logic [lkx_pkg::WordW-1:0] prdata,
  output logic                      pready
);

  lkx_pkg::lkx_cmd_t cmd;
  lkx_pkg::lkx_sts_t sts;
  lkx_pkg::lkx_cfg_t cfg;

  // Bus write decode, register index from word address
  assign pready    = 1'b1;
  assign cfg.we    = psel & penable & pwrite & pready;
  assign cfg.idx   = paddr[lkx_pkg::AddrW-1:2];
  assign cfg.wdata = pwdata;

  lkx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lkx_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_i      (cfg),
    .rd_idx_i   (paddr[lkx_pkg::AddrW-1:2]),
    .rd_data_o  (prdata)
  );

endmodule

// File: src/lkx_checker.sv
// Port-level checks for the LCG cipher, bound to the top level.
// Depends on lkx_pkg and lcg_keystream_xor_cipher.
`timescale 1ns / 1ps

module lkx_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input lkx_pkg::lkx_out_t         out_data_o,
  input logic                      psel,
  input logic                      pready
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // An accepted byte keeps the input side busy through multiply and add
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input taken again before the byte was processed");

  // A new result only appears at the end of a byte's processing
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no byte in flight");

  // Bus never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("bus access not ready");

endmodule

bind lcg_keystream_xor_cipher lkx_checker u_lkx_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the LCG keystream XOR cipher.
// Depends on lkx_pkg and lcg_keystream_xor_cipher; predicts every output
// transaction and programs the registers over the APB-style port.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumRegs      = 1 << lkx_pkg::RegIdxW;
  localparam int unsigned RandomItems  = 1250;
  localparam int unsigned HoldCycles   = 800;
  localparam int unsigned HoldAfter    = 400;
  localparam int unsigned SettleCycles = 40;

  // DUT connections, all inputs known from time zero
  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  lkx_pkg::lkx_in_t                  in_data_i   = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  lkx_pkg::lkx_out_t                 out_data_o;
  logic                              psel        = 1'b0;
  logic                              penable     = 1'b0;
  logic                              pwrite      = 1'b0;
  logic [lkx_pkg::AddrW-1:0]         paddr       = '0;
  logic [lkx_pkg::WordW-1:0]         pwdata      = '0;
  logic [lkx_pkg::WordW-1:0]         prdata;
  logic                              pready;

  // Shadow copy of the registers and the generator state
  logic [lkx_pkg::WordW-1:0]         seed_reg;
  logic [lkx_pkg::WordW-1:0]         mult_reg;
  logic [lkx_pkg::WordW-1:0]         incr_reg;
  logic [lkx_pkg::WordW-1:0]         mod_reg;
  logic [lkx_pkg::WordW-1:0]         key_state;

  lkx_pkg::lkx_in_t                  plain_q[$];       // bytes waiting to be offered
  lkx_pkg::lkx_out_t                 cipher_due_q[$];  // predicted output transactions
  int unsigned                       n_accepted     = 0;
  int unsigned                       mismatch_count = 0;
  int unsigned                       send_gap       = 0;
  int unsigned                       stall_left     = 0;
  logic                              calm           = 1'b0;  // no idling on either side
  logic                              hold_off       = 1'b0;

  lcg_keystream_xor_cipher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the generator and XOR the byte with the new low byte
  function automatic lkx_pkg::lkx_out_t encrypt_byte(lkx_pkg::lkx_in_t item);
    logic [lkx_pkg::WordW-1:0] nxt_state;
    lkx_pkg::lkx_out_t         res;
    nxt_state = mult_reg * key_state + incr_reg;
    if (mod_reg != '0) nxt_state = nxt_state % mod_reg;
    key_state    = nxt_state;
    res.out_byte = item.data_byte ^ nxt_state[7:0];
    res.out_last = item.is_last;
    return res;
  endfunction

  function automatic void shadow_write(logic [lkx_pkg::RegIdxW-1:0] idx,
                                       logic [lkx_pkg::WordW-1:0] val);
    case (idx)
      lkx_pkg::REG_SEED: begin
        seed_reg  = val;
        key_state = val;
      end
      lkx_pkg::REG_MULTIPLIER: mult_reg = val;
      lkx_pkg::REG_INCREMENT:  incr_reg = val;
      lkx_pkg::REG_MODULUS:    if (val != '0) mod_reg = val;  // zero write is dropped
      default: ;
    endcase
  endfunction

  function automatic logic [lkx_pkg::WordW-1:0] shadow_value(
    logic [lkx_pkg::RegIdxW-1:0] idx);
    case (idx)
      lkx_pkg::REG_SEED:       return seed_reg;
      lkx_pkg::REG_MULTIPLIER: return mult_reg;
      lkx_pkg::REG_INCREMENT:  return incr_reg;
      default:                 return mod_reg;
    endcase
  endfunction

  function automatic void note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Mostly short gaps, a few long ones, none while calm
  function automatic int unsigned draw_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [lkx_pkg::WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [lkx_pkg::WordW-1:0] rand_modulus();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(1, 31);
      3:       return $urandom_range(1, 300);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_item(logic [7:0] data, logic last);
    lkx_pkg::lkx_in_t item;
    item.data_byte = data;
    item.is_last   = last;
    plain_q.push_back(item);
  endfunction

  // APB write: setup cycle, then access until pready
  task automatic reg_write(input logic [lkx_pkg::RegIdxW-1:0] idx,
                           input logic [lkx_pkg::WordW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_write(idx, val);
  endtask

  // APB read of every register, compared with the shadow copy
  task automatic check_regs();
    logic [lkx_pkg::RegIdxW-1:0] idx;
    for (int i = 0; i < NumRegs; i++) begin
      idx = lkx_pkg::RegIdxW'(i);
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== shadow_value(idx))
        note_error($sformatf("register %0d read: expected 0x%08h, got 0x%08h",
                             idx, shadow_value(idx), prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Wait until every queued byte has gone in and every result come out;
  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    while (plain_q.size() != 0 || in_valid_i || cipher_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Driver: offers queued bytes, holds the payload while stalled
  always @(posedge clk_i) begin : drive_proc
    lkx_pkg::lkx_in_t nxt_item;
    logic             nxt_valid;
    nxt_item  = in_data_i;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        cipher_due_q.push_back(encrypt_byte(in_data_i));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          send_gap--;
          nxt_valid = 1'b0;
        end else if (plain_q.size() != 0) begin
          nxt_item  = plain_q.pop_front();
          nxt_valid = 1'b1;
          send_gap  = draw_gap();
        end else begin
          nxt_valid = 1'b0;
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_item;
  end

  // Monitor: checks each output transaction, stalls at random
  always @(posedge clk_i) begin : monitor_proc
    logic              nxt_stall;
    lkx_pkg::lkx_out_t due;
    nxt_stall = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (cipher_due_q.size() == 0) begin
          note_error($sformatf("unexpected result: byte 0x%02h last %0b",
                               out_data_o.out_byte, out_data_o.out_last));
        end else begin
          due = cipher_due_q.pop_front();
          if (out_data_o.out_byte !== due.out_byte)
            note_error($sformatf("out_byte: expected 0x%02h, got 0x%02h",
                                 due.out_byte, out_data_o.out_byte));
          if (out_data_o.out_last !== due.out_last)
            note_error($sformatf("out_last: expected %0b, got %0b",
                                 due.out_last, out_data_o.out_last));
        end
      end
      if (hold_off) begin
        nxt_stall = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else begin
        stall_left = draw_gap();
        if (stall_left != 0) begin
          stall_left--;
          nxt_stall = 1'b1;
        end
      end
    end
    out_stall_i <= nxt_stall;
  end

  // Long receiver hold-off mid-run, started while bytes are still queued,
  // so the block backs up onto its input
  initial begin : hold_off_proc
    while (!(n_accepted >= HoldAfter && plain_q.size() >= 2))
      @(posedge clk_i);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog
  initial begin : watchdog_proc
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // Stimulus sequence
  initial begin : stimulus_proc
    int unsigned        sent;
    int unsigned        phase_len;
    int unsigned        n;
    int unsigned        buf_len;
    logic [NumRegs-1:0] mask;
    seed_reg  = lkx_pkg::SEED_RST;
    mult_reg  = lkx_pkg::MULTIPLIER_RST;
    incr_reg  = lkx_pkg::INCREMENT_RST;
    mod_reg   = lkx_pkg::MODULUS_RST;
    key_state = lkx_pkg::SEED_RST;
    sent      = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    // Reset settings, byte extremes and both marker values
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b1);
    queue_item(8'hAA, 1'b0);
    queue_item(8'h55, 1'b1);
    queue_item(8'h01, 1'b0);
    queue_item(8'h80, 1'b1);
    drain();

    // Degenerate generator: modulus 1 forces a zero keystream
    reg_write(lkx_pkg::REG_MULTIPLIER, '0);
    reg_write(lkx_pkg::REG_INCREMENT, '0);
    reg_write(lkx_pkg::REG_MODULUS, 32'd1);
    reg_write(lkx_pkg::REG_SEED, '1);
    check_regs();
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b1);
    queue_item(8'h5A, 1'b1);
    drain();

    // Zero modulus write must leave modulus at 1
    reg_write(lkx_pkg::REG_INCREMENT, 32'h0001_2345);
    reg_write(lkx_pkg::REG_MODULUS, '0);
    check_regs();
    queue_item(8'hC3, 1'b0);
    queue_item(8'h3C, 1'b1);
    drain();

    // All-ones settings, state wraps to the modulus
    reg_write(lkx_pkg::REG_MULTIPLIER, '1);
    reg_write(lkx_pkg::REG_INCREMENT, '1);
    reg_write(lkx_pkg::REG_MODULUS, '1);
    reg_write(lkx_pkg::REG_SEED, '1);
    check_regs();
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h81, 1'b0);
    queue_item(8'h7E, 1'b1);
    drain();

    // Power-of-two modulus
    reg_write(lkx_pkg::REG_MODULUS, 32'h8000_0000);
    reg_write(lkx_pkg::REG_INCREMENT, 32'd1);
    reg_write(lkx_pkg::REG_SEED, 32'h7FFF_FFFF);
    check_regs();
    queue_item(8'hA5, 1'b0);
    queue_item(8'h5A, 1'b1);
    queue_item(8'hF0, 1'b0);
    drain();

    // Random phases: new settings, then mostly whole buffers
    while (sent < RandomItems) begin
      calm <= ($urandom_range(0, 3) == 0);
      mask = NumRegs'($urandom_range(1, (1 << NumRegs) - 1));
      if (mask[lkx_pkg::REG_MULTIPLIER])
        reg_write(lkx_pkg::REG_MULTIPLIER, rand_word());
      if (mask[lkx_pkg::REG_INCREMENT])
        reg_write(lkx_pkg::REG_INCREMENT, rand_word());
      if (mask[lkx_pkg::REG_MODULUS])
        reg_write(lkx_pkg::REG_MODULUS, rand_modulus());
      if (mask[lkx_pkg::REG_SEED])
        reg_write(lkx_pkg::REG_SEED, rand_word());
      check_regs();
      phase_len = $urandom_range(40, 160);
      n = 0;
      while (n < phase_len) begin
        if ($urandom_range(0, 9) != 0) begin
          buf_len = $urandom_range(1, 24);
          for (int j = 0; j < buf_len; j++)
            queue_item(8'($urandom_range(0, 255)), j == buf_len - 1);
        end else begin
          // noise: marker at random positions
          buf_len = $urandom_range(1, 8);
          for (int j = 0; j < buf_len; j++)
            queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        n += buf_len;
      end
      sent += n;
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
